// File: rtl/cbn_pkg.sv
// ----------------------------------------------------------------------------
// cbn_pkg
// shared types and helpers of the contact basis block
// ----------------------------------------------------------------------------
package cbn_pkg;

  localparam int RBITS = 15;  // magnitude bits found by the cell chain
  localparam int QW    = 32;  // squared length width
  localparam int TW    = 62;  // target width (c^2 << 30)
  localparam int SW    = 63;  // running r^2*q width
  localparam int RQW   = 47;  // running r*q width

  // data handed from cell to cell, two tangent components side by side
  typedef struct packed {
    logic                         valid;
    logic                         xsel;
    logic                         degen;
    logic signed [15:0]           nx;
    logic signed [15:0]           ny;
    logic signed [15:0]           nz;
    logic [QW-1:0]                q;
    logic [1:0]                   neg;
    logic [1:0]                   full;
    logic [1:0][TW-1:0]           tgt;
    logic [1:0][SW-1:0]           s;
    logic [1:0][RQW-1:0]          rq;
    logic [1:0][RBITS-1:0]        r;
  } cbn_cell_t;

  // floor((v + 2^14) / 2^15), saturated to q1.15
  function automatic logic signed [15:0] round_q15(input logic signed [33:0] v);
    logic signed [34:0] w;
    logic signed [19:0] h;
    begin
      w = 35'(v) + 35'sd16384;
      h = 20'(w >>> 15);
      if (h > 20'sd32767) round_q15 = 16'sd32767;
      else if (h < -20'sd32768) round_q15 = -16'sd32768;
      else round_q15 = h[15:0];
    end
  endfunction

endpackage

// File: rtl/cbn_in_if.sv
// ----------------------------------------------------------------------------
// cbn_in_if
// normal vector channel
// ----------------------------------------------------------------------------
interface cbn_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  modport source (output valid, normal_x, normal_y, normal_z, input ready);
  modport sink   (input valid, normal_x, normal_y, normal_z, output ready);
endinterface

// File: rtl/cbn_out_if.sv
// ----------------------------------------------------------------------------
// cbn_out_if
// contact basis matrix channel
// ----------------------------------------------------------------------------
interface cbn_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] m00, m01, m02;
  logic signed [15:0] m10, m11, m12;
  logic signed [15:0] m20, m21, m22;
  logic               degenerate;
  modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  degenerate, input ready);
  modport sink   (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  degenerate, output ready);
endinterface

// File: rtl/cbn_front.sv
// ----------------------------------------------------------------------------
// cbn_front
// axis choice, squared length and search targets
// ----------------------------------------------------------------------------
module cbn_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 valid,
  input  logic signed [15:0]   nx,
  input  logic signed [15:0]   ny,
  input  logic signed [15:0]   nz,
  output cbn_pkg::cbn_cell_t   q_out
);
  localparam int QWL = cbn_pkg::QW;
  logic [16:0] ax, ay, az, asel;
  logic        xsel;
  logic [33:0] nz2, sel2;
  logic [QWL-1:0] qsum;
  cbn_pkg::cbn_cell_t d;

  always_comb begin
    ax   = nx[15] ? 17'(-{nx[15], nx}) : 17'({nx[15], nx});
    ay   = ny[15] ? 17'(-{ny[15], ny}) : 17'({ny[15], ny});
    az   = nz[15] ? 17'(-{nz[15], nz}) : 17'({nz[15], nz});
    xsel = ax > ay;
    asel = xsel ? ax : ay;
    nz2  = 34'(az) * 34'(az);
    sel2 = 34'(asel) * 34'(asel);
    qsum = QWL'(nz2 + sel2);
    d          = '0;
    d.valid    = valid;
    d.xsel     = xsel;
    d.degen    = qsum == '0;
    d.nx       = nx;
    d.ny       = ny;
    d.nz       = nz;
    d.q        = qsum;
    // component 0 comes from nz, component 1 from the chosen axis
    d.neg[0]   = xsel ? nz[15] : (!nz[15] && nz != '0);
    d.neg[1]   = xsel ? (!nx[15] && nx != '0) : ny[15];
    d.full[0]  = sel2 == '0;
    d.full[1]  = nz2 == '0;
    d.tgt[0]   = cbn_pkg::TW'(nz2) << 30;
    d.tgt[1]   = cbn_pkg::TW'(sel2) << 30;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else if (en) begin
      q_out <= d;
    end
  end
endmodule

// File: rtl/cbn_cell.sv
// ----------------------------------------------------------------------------
// cbn_cell
// one bit of the reciprocal square root search for both components
// ----------------------------------------------------------------------------
module cbn_cell #(
  parameter int BIT = 14
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  cbn_pkg::cbn_cell_t d_in,
  output cbn_pkg::cbn_cell_t q_out
);
  cbn_pkg::cbn_cell_t d;
  logic [cbn_pkg::SW-1:0] cand [2];

  always_comb begin
    d = d_in;
    for (int i = 0; i < 2; i++) begin
      // (r + 2^k)^2 q = r^2 q + 2^(k+1) r q + 2^(2k) q
      cand[i] = d_in.s[i] + (cbn_pkg::SW'(d_in.rq[i]) << (BIT + 1))
              + (cbn_pkg::SW'(d_in.q) << (2 * BIT));
      if (cand[i] <= cbn_pkg::SW'(d_in.tgt[i])) begin
        d.s[i]  = cand[i];
        d.rq[i] = d_in.rq[i] + (cbn_pkg::RQW'(d_in.q) << BIT);
        d.r[i]  = d_in.r[i] | (cbn_pkg::RBITS'(1) << BIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_out.valid <= 1'b0;
    end else if (en) begin
      q_out <= d;
    end
  end
endmodule

// File: rtl/cbn_back.sv
// ----------------------------------------------------------------------------
// cbn_back
// tangent signs, cross product and rounding to the output register
// ----------------------------------------------------------------------------
module cbn_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                en,
  input  cbn_pkg::cbn_cell_t  d_in,
  output logic                valid,
  output logic signed [15:0]  nx, ny, nz,
  output logic signed [15:0]  t0x, t0y, t0z,
  output logic signed [15:0]  t1x, t1y, t1z,
  output logic                degen
);
  // stage a: signed tangent components
  logic               a_valid, a_xsel, a_degen;
  logic signed [15:0] a_nx, a_ny, a_nz, a_v0, a_v1;
  logic signed [15:0] v [2];
  // stage b: products
  logic               b_valid, b_xsel, b_degen;
  logic signed [15:0] b_nx, b_ny, b_nz, b_v0, b_v1;
  logic signed [31:0] pa, pb, pc, pd;
  logic signed [33:0] s1, s2, s3;

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      if (d_in.degen) v[i] = '0;
      else if (d_in.full[i]) v[i] = d_in.neg[i] ? -16'sd32768 : 16'sd32767;
      else if (d_in.neg[i]) v[i] = -$signed({1'b0, d_in.r[i]});
      else v[i] = $signed({1'b0, d_in.r[i]});
    end
  end

  always_comb begin
    if (b_xsel) begin
      s1 = 34'(pa);
      s2 = 34'(pb) - 34'(pc);
      s3 = -34'(pd);
    end else begin
      s1 = 34'(pa) - 34'(pb);
      s2 = -34'(pc);
      s3 = 34'(pd);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      valid   <= 1'b0;
    end else if (en) begin
      a_valid <= d_in.valid;
      b_valid <= a_valid;
      valid   <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_xsel  <= d_in.xsel;
      a_degen <= d_in.degen;
      a_nx    <= d_in.nx;
      a_ny    <= d_in.ny;
      a_nz    <= d_in.nz;
      a_v0    <= v[0];
      a_v1    <= v[1];
      b_xsel  <= a_xsel;
      b_degen <= a_degen;
      b_nx    <= a_nx;
      b_ny    <= a_ny;
      b_nz    <= a_nz;
      b_v0    <= a_v0;
      b_v1    <= a_v1;
      pa      <= a_ny * a_v1;
      pb      <= a_nz * a_v0;
      pc      <= a_nx * a_v1;
      pd      <= (a_xsel ? a_ny : a_nx) * a_v0;
      nx      <= b_nx;
      ny      <= b_ny;
      nz      <= b_nz;
      degen   <= b_degen;
      t0x     <= b_xsel ? b_v0 : 16'sd0;
      t0y     <= b_xsel ? 16'sd0 : b_v0;
      t0z     <= b_v1;
      t1x     <= cbn_pkg::round_q15(s1);
      t1y     <= cbn_pkg::round_q15(s2);
      t1z     <= cbn_pkg::round_q15(s3);
    end
  end
endmodule

// File: rtl/contact_basis_from_normal_core.sv
// pipeline: front stage, 15 search cells, tangent, product and rounding stages
// throughput: one normal per cycle; the whole pipe holds while a finished
// result waits and the sink is not ready
// reset: synchronous, clears every stage valid bit, no data is cleared
// ----------------------------------------------------------------------------
// contact_basis_from_normal_core
// orthonormal contact basis from a q1.15 contact normal
// ----------------------------------------------------------------------------
module contact_basis_from_normal_core (
  input  logic       clk,
  input  logic       rst,
  cbn_in_if.sink     in_ch,
  cbn_out_if.source  out_ch
);
  localparam int NCELL = cbn_pkg::RBITS;

  // chain of cells, link 0 is the front register
  cbn_pkg::cbn_cell_t link [NCELL+1];
  logic en;

  // global advance: hold only when the output register is full and stalled
  assign en          = !out_ch.valid || out_ch.ready;
  assign in_ch.ready = en;

  // pick the axis pair and form q and the two search targets
  cbn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .valid (in_ch.valid),
    .nx    (in_ch.normal_x),
    .ny    (in_ch.normal_y),
    .nz    (in_ch.normal_z),
    .q_out (link[0])
  );

  // one cell per magnitude bit, msb first: largest r with r^2 q <= c^2 2^30
  for (genvar g = 0; g < NCELL; g++) begin : g_cell
    cbn_cell #(.BIT(NCELL - 1 - g)) u_cell (
      .clk   (clk),
      .rst   (rst),
      .en    (en),
      .d_in  (link[g]),
      .q_out (link[g+1])
    );
  end

  // signs, second tangent as n x t0, rounding, output register
  cbn_back u_back (
    .clk   (clk),
    .rst   (rst),
    .en    (en),
    .d_in  (link[NCELL]),
    .valid (out_ch.valid),
    .nx    (out_ch.m00),
    .ny    (out_ch.m10),
    .nz    (out_ch.m20),
    .t0x   (out_ch.m01),
    .t0y   (out_ch.m11),
    .t0z   (out_ch.m21),
    .t1x   (out_ch.m02),
    .t1y   (out_ch.m12),
    .t1z   (out_ch.m22),
    .degen (out_ch.degenerate)
  );
endmodule

// File: rtl/cbn_checker.sv
// ----------------------------------------------------------------------------
// cbn_checker
// port level checks of the contact basis block
// ----------------------------------------------------------------------------
module cbn_checker (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [15:0] m00, m10, m20,
  input logic signed [15:0] m01, m11, m21,
  input logic signed [15:0] m02, m12, m22,
  input logic               degenerate
);
  // a degenerate result carries zero tangents
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> m01 == 0 && m11 == 0 && m21 == 0 &&
      m02 == 0 && m12 == 0 && m22 == 0)
    else $error("degenerate result with nonzero tangent");

  // degenerate only for the zero normal
  a_degen_normal: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> m00 == 0 && m10 == 0 && m20 == 0)
    else $error("degenerate flag on nonzero normal");

  // nothing comes out right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(m01) && $stable(m22))
    else $error("stalled result changed");
endmodule

bind contact_basis_from_normal_core cbn_checker u_cbn_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .m00        (out_ch.m00),
  .m10        (out_ch.m10),
  .m20        (out_ch.m20),
  .m01        (out_ch.m01),
  .m11        (out_ch.m11),
  .m21        (out_ch.m21),
  .m02        (out_ch.m02),
  .m12        (out_ch.m12),
  .m22        (out_ch.m22),
  .degenerate (out_ch.degenerate)
);

// File: tb/cbn_basis_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// cbn_basis_checker
// predicts the contact basis of every accepted normal and compares results
// ----------------------------------------------------------------------------
module cbn_basis_checker (
  input  logic      clk,
  input  logic      rst,
  cbn_in_if.sink    in_mon,
  cbn_out_if.sink   out_mon,
  output int        fail_count,
  output int        pending,
  output int        matrix_count,
  output int        degen_count
);

  typedef struct packed {
    logic signed [15:0] m00, m01, m02;
    logic signed [15:0] m10, m11, m12;
    logic signed [15:0] m20, m21, m22;
    logic               degenerate;
  } basis_t;

  basis_t expected_basis_q[$];

  // truncated |c| * 32768 / sqrt(q)
  function automatic longint unit_mag(longint c, longint q);
    longint c2;
    longint r;
    longint cand;
    c2 = c * c;
    if (q <= c2) return 32768;
    r = 0;
    for (int b = 14; b >= 0; b--) begin
      cand = r | (longint'(1) << b);
      if (cand * cand * q <= (c2 << 30)) r = cand;
    end
    return r;
  endfunction

  function automatic logic signed [15:0] clip16(longint v);
    if (v > 32767) return 16'sd32767;
    if (v < -32768) return -16'sd32768;
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] q15_round(longint v);
    longint w;
    w = v + 16384;
    return clip16(w >>> 15);
  endfunction

  function automatic basis_t basis_of(logic signed [15:0] x, logic signed [15:0] y,
                                      logic signed [15:0] z);
    basis_t o;
    longint nx, ny, nz, ax, ay, az, q, t0x, t0y, t0z;
    nx = x; ny = y; nz = z;
    ax = nx < 0 ? -nx : nx;
    ay = ny < 0 ? -ny : ny;
    az = nz < 0 ? -nz : nz;
    o = '0;
    o.m00 = x; o.m10 = y; o.m20 = z;
    t0x = 0; t0y = 0; t0z = 0;
    if (ax > ay) begin
      q = az * az + ax * ax;
      if (q == 0) o.degenerate = 1'b1;
      else begin
        t0x = clip16(nz < 0 ? -unit_mag(az, q) : unit_mag(az, q));
        t0z = clip16(nx > 0 ? -unit_mag(ax, q) : unit_mag(ax, q));
        o.m02 = q15_round(ny * t0z);
        o.m12 = q15_round(nz * t0x - nx * t0z);
        o.m22 = q15_round(-(ny * t0x));
      end
    end else begin
      q = az * az + ay * ay;
      if (q == 0) o.degenerate = 1'b1;
      else begin
        t0y = clip16(nz > 0 ? -unit_mag(az, q) : unit_mag(az, q));
        t0z = clip16(ny < 0 ? -unit_mag(ay, q) : unit_mag(ay, q));
        o.m02 = q15_round(ny * t0z - nz * t0y);
        o.m12 = q15_round(-(nx * t0z));
        o.m22 = q15_round(nx * t0y);
      end
    end
    o.m01 = t0x[15:0]; o.m11 = t0y[15:0]; o.m21 = t0z[15:0];
    return o;
  endfunction

  assign pending = expected_basis_q.size();

  always @(posedge clk) begin
    basis_t got;
    basis_t exp_b;
    if (rst) begin
      fail_count <= 0;
      matrix_count <= 0;
      degen_count <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready)
        expected_basis_q.push_back(basis_of(in_mon.normal_x, in_mon.normal_y,
                                            in_mon.normal_z));
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.m00, out_mon.m01, out_mon.m02, out_mon.m10, out_mon.m11,
               out_mon.m12, out_mon.m20, out_mon.m21, out_mon.m22,
               out_mon.degenerate};
        matrix_count <= matrix_count + 1;
        degen_count <= degen_count + got.degenerate;
        if (expected_basis_q.size() == 0) begin
          if (fail_count < 10) $display("error: unexpected result %h", got);
          fail_count <= fail_count + 1;
        end else begin
          exp_b = expected_basis_q.pop_front();
          if (got !== exp_b) begin
            if (fail_count < 10)
              $display("error: basis mismatch exp %h got %h", exp_b, got);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the contact basis core
// directed corner normals, then random unit and raw normals under four idle
// patterns and one long sink hold-off; a side checker predicts every result
// ----------------------------------------------------------------------------
module tb;

  logic clk = 1'b0;
  logic rst = 1'b1;

  cbn_in_if  in_ch ();
  cbn_out_if out_ch ();

  // idle percentages for sender and receiver, changed per phase
  int src_idle = 0;
  int snk_idle = 0;
  bit hold_off = 1'b0;
  int hold_cycles = 0;
  int cycle_count = 0;
  int fail_count, pending, matrix_count, degen_count;

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  contact_basis_from_normal_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  cbn_basis_checker u_chk (
    .clk          (clk),
    .rst          (rst),
    .in_mon       (in_ch.sink),
    .out_mon      (out_ch.sink),
    .fail_count   (fail_count),
    .pending      (pending),
    .matrix_count (matrix_count),
    .degen_count  (degen_count)
  );

  initial begin
    in_ch.valid = 1'b0;
    in_ch.normal_x = '0;
    in_ch.normal_y = '0;
    in_ch.normal_z = '0;
    out_ch.ready = 1'b0;
  end

  // receiver: random stalls, plus a long counted hold-off when requested
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ch.ready <= 1'b0;
    end else if (hold_off) begin
      hold_cycles <= 300;
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= snk_idle);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 200000) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // offer one normal, with random leading gaps, until the transfer
  task automatic send_normal(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    while ($urandom_range(99) < src_idle) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.normal_x <= x;
    in_ch.normal_y <= y;
    in_ch.normal_z <= z;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // roughly unit normal with random direction and signs
  task automatic send_unit_normal();
    int a, b, c;
    a = $urandom_range(32767);
    b = $urandom_range(32767 - a / 2);
    c = 32767 - ((a > b) ? a : b) / 2;
    if ($urandom_range(1)) a = -a;
    if ($urandom_range(1)) b = -b;
    if ($urandom_range(1)) c = -c;
    case ($urandom_range(2))
      0: send_normal(a[15:0], b[15:0], c[15:0]);
      1: send_normal(c[15:0], a[15:0], b[15:0]);
      default: send_normal(b[15:0], c[15:0], a[15:0]);
    endcase
  endtask

  task automatic run_phase(int s_idle, int r_idle, int n);
    src_idle = s_idle;
    snk_idle = r_idle;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0)
        send_normal(16'($urandom), 16'($urandom), 16'($urandom));
      else
        send_unit_normal();
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: zero normal, axes, extremes, ties
    send_normal(16'h0000, 16'h0000, 16'h0000);
    send_normal(16'h7fff, 16'h0000, 16'h0000);
    send_normal(16'h8000, 16'h0000, 16'h0000);
    send_normal(16'h0000, 16'h7fff, 16'h0000);
    send_normal(16'h0000, 16'h8000, 16'h0000);
    send_normal(16'h0000, 16'h0000, 16'h7fff);
    send_normal(16'h0000, 16'h0000, 16'h8000);
    send_normal(16'h8000, 16'h8000, 16'h8000);
    send_normal(16'h7fff, 16'h7fff, 16'h7fff);
    send_normal(16'h5a82, 16'h5a82, 16'h0000);   // tie, takes the y/z pair
    send_normal(16'h5a82, 16'ha57e, 16'h0000);
    send_normal(16'h49e7, 16'hb619, 16'h49e7);
    send_normal(16'h8000, 16'h7fff, 16'h0001);
    send_normal(16'h0001, 16'h0000, 16'h0000);
    send_normal(16'h0000, 16'hffff, 16'h0000);
    send_normal(16'hffff, 16'h0001, 16'h7fff);
    send_normal(16'h7fff, 16'h0000, 16'h8000);   // non-unit, saturates
    send_normal(16'h8000, 16'h0001, 16'h8000);

    run_phase(0, 0, 100);
    run_phase(45, 0, 100);
    run_phase(0, 45, 100);

    // long sink hold-off while the sender keeps offering
    hold_off <= 1'b1;
    @(posedge clk);
    hold_off <= 1'b0;
    run_phase(0, 0, 40);

    run_phase(35, 35, 100);
    in_ch.valid <= 1'b0;

    snk_idle = 0;
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    $display("covered %0d matrices, %0d degenerate, under four idle patterns",
             matrix_count, degen_count);
    $display("corner normals, ties, non-unit and random normals plus one long stall");
    if (fail_count == 0 && pending == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
